// ----- design/sirt_pkg.sv -----
`default_nettype none

package sirt_pkg;

    // Value and text geometry
    localparam int VALUE_W    = 32;
    localparam int NUM_DIGITS = VALUE_W;              // radix 2 needs one digit per bit
    localparam int ALPHA_SYMS = 32;                   // symbols held in the alphabet registers
    localparam int MAX_BASE   = 32;                   // largest radix accepted as valid
    localparam int SYM_W      = 8;
    localparam int LEN_W      = 6;
    localparam int DIGIT_W    = $clog2(ALPHA_SYMS);
    localparam int CNT_W      = $clog2(NUM_DIGITS);
    localparam int NDIG_W     = $clog2(NUM_DIGITS + 1);

    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(NUM_DIGITS - 1);

    // Register port geometry
    localparam int PADDR_W       = 6;
    localparam int PDATA_W       = 64;
    localparam int SYMS_PER_WORD = PDATA_W / SYM_W;
    localparam int ALPHA_WORDS   = ALPHA_SYMS / SYMS_PER_WORD;
    localparam int REG_IDX_W     = 3;

    localparam logic [REG_IDX_W-1:0] REG_ALPHABET_0 = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_ALPHABET_1 = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_ALPHABET_2 = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_ALPHABET_3 = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_RADIX_LEN  = 3'd4;

    localparam logic [SYM_W-1:0] SYM_PLUS  = 8'h2B;
    localparam logic [SYM_W-1:0] SYM_MINUS = 8'h2D;
    localparam logic [SYM_W-1:0] SYM_NONE  = 8'h00;

    typedef struct packed {
        logic [ALPHA_SYMS-1:0][SYM_W-1:0] symbols;
        logic [LEN_W-1:0]                 base_len;
    } cfg_t;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_CONV = 3'b010,
        ST_EMIT = 3'b100
    } state_t;

endpackage

`default_nettype wire

// ----- design/sirt_core.sv -----
`default_nettype none

module sirt_core (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire sirt_pkg::cfg_t                   cfg,
    input  wire logic                             s_valid,
    output logic                                  s_ready,
    input  wire logic signed [sirt_pkg::VALUE_W-1:0] s_value,
    output logic                                  m_valid,
    input  wire logic                             m_ready,
    output logic [sirt_pkg::SYM_W-1:0]            m_symbol,
    output logic                                  m_last,
    output logic                                  m_bad_alphabet
);
    import sirt_pkg::*;

    state_t                                state_reg, state_next;
    logic [VALUE_W-1:0]                    mag_reg, mag_next;
    logic                                  neg_reg, neg_next;
    logic [CNT_W-1:0]                      cnt_reg, cnt_next;
    logic [NUM_DIGITS-1:0][DIGIT_W-1:0]    digit_reg, digit_next;
    logic [NDIG_W-1:0]                     ndig_reg, ndig_next;
    logic                                  bad_reg, bad_next;
    logic                                  sign_pend_reg, sign_pend_next;
    logic [CNT_W-1:0]                      ptr_reg, ptr_next;
    logic                                  m_valid_reg, m_valid_next;
    logic [SYM_W-1:0]                      m_symbol_reg, m_symbol_next;
    logic                                  m_last_reg, m_last_next;
    logic                                  m_bad_reg, m_bad_next;

    // digit array: double in base r and add the next magnitude bit
    logic [NUM_DIGITS:0]                   carry;
    logic [NUM_DIGITS-1:0]                 gen, prop;
    logic [NUM_DIGITS-1:0][LEN_W-1:0]      dsum, ddiff;
    logic [NUM_DIGITS-1:0][DIGIT_W-1:0]    step_digit;
    logic [NDIG_W-1:0]                     step_ndig;

    // alphabet check for symbol cnt_reg
    logic [SYM_W-1:0]                      chk_sym;
    logic                                  chk_dup;
    logic                                  chk_bad;
    logic                                  len_bad;

    logic                                  out_free;
    logic [DIGIT_W-1:0]                    emit_digit;
    logic [VALUE_W-1:0]                    in_mag;

    assign s_ready        = (state_reg == ST_IDLE);
    assign m_valid        = m_valid_reg;
    assign m_symbol       = m_symbol_reg;
    assign m_last         = m_last_reg;
    assign m_bad_alphabet = m_bad_reg;

    assign in_mag  = s_value[VALUE_W-1] ? (VALUE_W'(0) - VALUE_W'(s_value))
                                        : VALUE_W'(s_value);
    assign len_bad = (cfg.base_len < LEN_W'(2)) || (cfg.base_len > LEN_W'(MAX_BASE));

    always_comb begin
        carry[0] = mag_reg[VALUE_W-1];
        for (int i = 0; i < NUM_DIGITS; i++) begin
            gen[i]       = LEN_W'({digit_reg[i], 1'b0}) >= cfg.base_len;
            prop[i]      = LEN_W'({digit_reg[i], 1'b1}) == cfg.base_len;
            carry[i+1]   = gen[i] | (prop[i] & carry[i]);
        end
        for (int i = 0; i < NUM_DIGITS; i++) begin
            dsum[i]       = LEN_W'({digit_reg[i], carry[i]});
            ddiff[i]      = dsum[i] - cfg.base_len;
            step_digit[i] = carry[i+1] ? ddiff[i][DIGIT_W-1:0] : dsum[i][DIGIT_W-1:0];
        end
        // a carry into the first unused digit makes it a 1 and stops there
        if ((ndig_reg != NDIG_W'(NUM_DIGITS)) && carry[ndig_reg]) begin
            step_ndig = ndig_reg + NDIG_W'(1);
        end else begin
            step_ndig = ndig_reg;
        end
    end

    always_comb begin
        chk_sym = cfg.symbols[cnt_reg];
        chk_dup = 1'b0;
        for (int j = 0; j < ALPHA_SYMS; j++) begin
            if ((CNT_W'(j) > cnt_reg) && (LEN_W'(j) < cfg.base_len) &&
                (cfg.symbols[j] == chk_sym)) begin
                chk_dup = 1'b1;
            end
        end
        chk_bad = (LEN_W'(cnt_reg) < cfg.base_len) &&
                  ((chk_sym == SYM_PLUS) || (chk_sym == SYM_MINUS) || chk_dup);
    end

    assign out_free   = !m_valid_reg || m_ready;
    assign emit_digit = digit_reg[ptr_reg];

    always_comb begin
        state_next     = state_reg;
        mag_next       = mag_reg;
        neg_next       = neg_reg;
        cnt_next       = cnt_reg;
        digit_next     = digit_reg;
        ndig_next      = ndig_reg;
        bad_next       = bad_reg;
        sign_pend_next = sign_pend_reg;
        ptr_next       = ptr_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_symbol_next  = m_symbol_reg;
        m_last_next    = m_last_reg;
        m_bad_next     = m_bad_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    mag_next   = in_mag;
                    neg_next   = s_value[VALUE_W-1];
                    cnt_next   = '0;
                    digit_next = '0;
                    ndig_next  = NDIG_W'(1);
                    bad_next   = len_bad;
                    state_next = ST_CONV;
                end
            end
            ST_CONV: begin
                digit_next = step_digit;
                ndig_next  = step_ndig;
                mag_next   = {mag_reg[VALUE_W-2:0], 1'b0};
                bad_next   = bad_reg | chk_bad;
                cnt_next   = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_LAST) begin
                    ptr_next       = CNT_W'(step_ndig - NDIG_W'(1));
                    sign_pend_next = neg_reg;
                    state_next     = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    if (bad_reg) begin
                        m_symbol_next = SYM_NONE;
                        m_last_next   = 1'b1;
                        m_bad_next    = 1'b1;
                        state_next    = ST_IDLE;
                    end else if (sign_pend_reg) begin
                        m_symbol_next  = SYM_MINUS;
                        m_last_next    = 1'b0;
                        m_bad_next     = 1'b0;
                        sign_pend_next = 1'b0;
                    end else begin
                        m_symbol_next = cfg.symbols[emit_digit];
                        m_last_next   = (ptr_reg == '0);
                        m_bad_next    = 1'b0;
                        ptr_next      = ptr_reg - CNT_W'(1);
                        if (ptr_reg == '0) begin
                            state_next = ST_IDLE;
                        end
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        mag_reg       <= mag_next;
        neg_reg       <= neg_next;
        cnt_reg       <= cnt_next;
        digit_reg     <= digit_next;
        ndig_reg      <= ndig_next;
        bad_reg       <= bad_next;
        sign_pend_reg <= sign_pend_next;
        ptr_reg       <= ptr_next;
        m_symbol_reg  <= m_symbol_next;
        m_last_reg    <= m_last_next;
        m_bad_reg     <= m_bad_next;
    end

    ap_accept_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == ST_CONV && cnt_reg == '0 &&
                                  ndig_reg == NDIG_W'(1)))
        else $error("conversion did not start cleanly after a request");

    ap_conv_to_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CONV && cnt_reg == CNT_LAST) |=> (state_reg == ST_EMIT))
        else $error("conversion did not hand over to emission");

    ap_ptr_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT) |-> (NDIG_W'(ptr_reg) < ndig_reg))
        else $error("digit pointer beyond significant digits");

    ap_err_form: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_bad_reg) |-> (m_last_reg && m_symbol_reg == SYM_NONE))
        else $error("error result not a single empty last character");

endmodule

`default_nettype wire

// ----- design/signed_integer_to_radix_text_top.sv -----
// A request is accepted only while idle; the first character is offered once the
// 32-step digit doubling unit has run, then n characters (1 to 33) follow at one
// character per cycle unless m_ready stalls the output.
// A finished last character may wait in the output register while the next
// request converts. Reset (aresetn low at a clock edge) idles the converter,
// drops any pending output and clears all configuration registers to zero.
`default_nettype none

module signed_integer_to_radix_text_top (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    // register port
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [sirt_pkg::PADDR_W-1:0]     paddr,
    input  wire logic [sirt_pkg::PDATA_W-1:0]     pwdata,
    output logic [sirt_pkg::PDATA_W-1:0]          prdata,
    output logic                                  pready,
    // value requests
    input  wire logic                             s_valid,
    output logic                                  s_ready,
    input  wire logic signed [sirt_pkg::VALUE_W-1:0] s_value,
    // text characters
    output logic                                  m_valid,
    input  wire logic                             m_ready,
    output logic [sirt_pkg::SYM_W-1:0]            m_symbol,
    output logic                                  m_last,
    output logic                                  m_bad_alphabet
);
    import sirt_pkg::*;

    // Alphabet bytes: symbol k sits in byte k mod 8 of register k / 8.
    logic [ALPHA_SYMS-1:0][SYM_W-1:0] alpha_reg;
    logic [LEN_W-1:0]                 base_len_reg;
    logic [REG_IDX_W-1:0]             reg_idx;
    logic                             wr_en;
    cfg_t                             cfg;

    // registers sit on 8-byte boundaries; byte offset bits are ignored
    assign reg_idx = paddr[PADDR_W-1:PADDR_W-REG_IDX_W];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    // Update on the access phase; writes to unused indexes drop silently.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            alpha_reg    <= '0;
            base_len_reg <= '0;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_ALPHABET_0: alpha_reg[0*SYMS_PER_WORD +: SYMS_PER_WORD] <= pwdata;
                REG_ALPHABET_1: alpha_reg[1*SYMS_PER_WORD +: SYMS_PER_WORD] <= pwdata;
                REG_ALPHABET_2: alpha_reg[2*SYMS_PER_WORD +: SYMS_PER_WORD] <= pwdata;
                REG_ALPHABET_3: alpha_reg[3*SYMS_PER_WORD +: SYMS_PER_WORD] <= pwdata;
                REG_RADIX_LEN:  base_len_reg <= pwdata[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    // Read back: zero for unused indexes.
    always_comb begin
        unique case (reg_idx)
            REG_ALPHABET_0: prdata = alpha_reg[0*SYMS_PER_WORD +: SYMS_PER_WORD];
            REG_ALPHABET_1: prdata = alpha_reg[1*SYMS_PER_WORD +: SYMS_PER_WORD];
            REG_ALPHABET_2: prdata = alpha_reg[2*SYMS_PER_WORD +: SYMS_PER_WORD];
            REG_ALPHABET_3: prdata = alpha_reg[3*SYMS_PER_WORD +: SYMS_PER_WORD];
            REG_RADIX_LEN:  prdata = PDATA_W'(base_len_reg);
            default:        prdata = '0;
        endcase
    end

    assign cfg.symbols  = alpha_reg;
    assign cfg.base_len = base_len_reg;

    // Converter: validates the alphabet and builds the base-r digits in one
    // pass over the magnitude bits, then streams '-' for a negative value and the digits
    // (or the single error character) through its output register.
    sirt_core u_core (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg            (cfg),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_value        (s_value),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_symbol       (m_symbol),
        .m_last         (m_last),
        .m_bad_alphabet (m_bad_alphabet)
    );

endmodule

`default_nettype wire
